// File: design/g2e_pkg.sv
`default_nettype none
package g2e_pkg;

  // angle format of the ports and of the internal degree angles
  localparam int ANGLE_FRAC_BITS = 24;
  localparam int ANG_SHIFT = 32 - ANGLE_FRAC_BITS;
  localparam int CORDIC_STAGES_DFLT = 24;

  // pipeline depths
  localparam int ANGLE_LAT = 3;
  localparam int SIDE_DEPTH = 78;
  localparam int ECEF_TAIL = 79;
  localparam int ROT_LAT = 7;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = 34;

  // configuration register indexes
  localparam logic [1:0] REG_REF_LAT = 2'd0;
  localparam logic [1:0] REG_REF_LON = 2'd1;
  localparam logic [1:0] REG_REF_ALT = 2'd2;

  // reset values of the reference point
  localparam logic [31:0] REF_LAT_RST = 32'd765564375;
  localparam logic [32:0] REF_LON_RST = 33'd155940021;
  localparam logic [27:0] REF_ALT_RST = 28'd231507;

  typedef logic signed [42:0] angle_t;
  typedef logic signed [32:0] trig_t;
  typedef logic signed [37:0] coord_t;
  typedef logic signed [39:0] sum_t;

  // degrees in Q32
  localparam angle_t ANG_FULL = 43'sd1546188226560;
  localparam angle_t ANG_HALF = 43'sd773094113280;
  localparam angle_t ANG_QUARTER = 43'sd386547056640;
  localparam angle_t ANG_Q45 = 43'sd193273528320;

  // ellipsoid and cordic constants
  localparam logic [32:0] A_MM = 33'd6378137000;
  localparam logic [32:0] E2_Q40 = 33'd7360548640;
  localparam logic [30:0] ONE_MINUS_E2_Q31 = 31'd2133107576;
  localparam trig_t CORDIC_K_Q30 = 33'sd652032874;
  localparam logic [63:0] DEG_PER_RAD_Q24 = 64'd961263669;

  typedef struct packed {
    logic        neg;
    logic [69:0] mag;
  } mprod_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    trig_t  slat;
    trig_t  clat;
    trig_t  slon;
    trig_t  clon;
  } ecef_t;

  // shift and subtract quotient, used for table constants only
  function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // arctangent of 2^-i in degrees Q32, from the odd power series
  function automatic angle_t atan_deg(input int i);
    logic signed [63:0] acc;
    logic [63:0] t;
    logic [63:0] scaled;
    int e;
    acc = '0;
    if (i == 0) return ANG_Q45;
    for (int k = 0; k < 32; k++) begin
      e = i * (2 * k + 1);
      if (e <= 60) begin
        t = long_div(64'd1 << (60 - e), 64'(2 * k + 1));
        if ((k & 1) != 0) acc = acc - $signed(t);
        else acc = acc + $signed(t);
      end
    end
    scaled = ((64'(acc) >> 28) * DEG_PER_RAD_Q24) >> 24;
    return $signed(scaled[42:0]);
  endfunction

  // magnitude product of a coordinate and a q30 factor
  function automatic mprod_t mq_prod(input coord_t a, input trig_t b);
    logic [37:0] ua;
    logic [32:0] ub;
    mprod_t p;
    ua = a[37] ? 38'(-a) : 38'(a);
    ub = b[32] ? 33'(-b) : 33'(b);
    p.neg = a[37] ^ b[32];
    p.mag = 70'(ua) * 70'(ub);
    return p;
  endfunction

  // scale back by 2^30, round half away from zero
  function automatic coord_t mq_round(input mprod_t p);
    logic [69:0] s;
    logic [37:0] m;
    s = p.mag + (70'd1 << 29);
    m = s[67:30];
    return p.neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [34:0] sat35(input sum_t v);
    if (v > 40'sd17179869183) return 35'h3FFFFFFFF;
    else if (v < -40'sd17179869184) return 35'h400000000;
    else return v[34:0];
  endfunction

endpackage
`default_nettype wire

// File: design/g2e_cordic.sv
`default_nettype none
module g2e_cordic import g2e_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DFLT
) (
  input  wire logic   clk,
  input  wire logic   en,
  input  wire angle_t theta_i,
  output trig_t       sin_o,
  output trig_t       cos_o
);

  angle_t wrap_r, fold_r;
  logic   flip_r;
  trig_t  cx_r [STAGES];
  trig_t  cy_r [STAGES];
  angle_t cz_r [STAGES];
  logic   cf_r [STAGES];
  trig_t  sin_r, cos_r;

  // wrap into one turn, then fold into the right half plane
  always_ff @(posedge clk) begin
    if (en) begin
      if (theta_i >= ANG_HALF) wrap_r <= theta_i - ANG_FULL;
      else if (theta_i < -ANG_HALF) wrap_r <= theta_i + ANG_FULL;
      else wrap_r <= theta_i;
      if (wrap_r > ANG_QUARTER) begin
        fold_r <= wrap_r - ANG_HALF;
        flip_r <= 1'b1;
      end else if (wrap_r < -ANG_QUARTER) begin
        fold_r <= wrap_r + ANG_HALF;
        flip_r <= 1'b1;
      end else begin
        fold_r <= wrap_r;
        flip_r <= 1'b0;
      end
    end
  end

  // rotation stages, one micro-rotation each
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam angle_t ATAN_I = atan_deg(i);
    trig_t  x_in, y_in;
    angle_t z_in;
    logic   f_in;
    if (i == 0) begin : g_first
      assign x_in = CORDIC_K_Q30;
      assign y_in = '0;
      assign z_in = fold_r;
      assign f_in = flip_r;
    end else begin : g_next
      assign x_in = cx_r[i-1];
      assign y_in = cy_r[i-1];
      assign z_in = cz_r[i-1];
      assign f_in = cf_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_in[42]) begin
          cx_r[i] <= x_in - (y_in >>> i);
          cy_r[i] <= y_in + (x_in >>> i);
          cz_r[i] <= z_in - ATAN_I;
        end else begin
          cx_r[i] <= x_in + (y_in >>> i);
          cy_r[i] <= y_in - (x_in >>> i);
          cz_r[i] <= z_in + ATAN_I;
        end
        cf_r[i] <= f_in;
      end
    end
  end

  // undo the fold
  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= cf_r[STAGES-1] ? -cy_r[STAGES-1] : cy_r[STAGES-1];
      cos_r <= cf_r[STAGES-1] ? -cx_r[STAGES-1] : cx_r[STAGES-1];
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule
`default_nettype wire

// File: design/g2e_ecef.sv
`default_nettype none
module g2e_ecef import g2e_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DFLT
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] lat_i,
  input  wire logic signed [32:0] lon_i,
  input  wire logic signed [27:0] alt_i,
  output ecef_t                   pos_o
);

  localparam int HD = STAGES + ANGLE_LAT;

  typedef struct packed {
    trig_t             slat;
    trig_t             clat;
    trig_t             slon;
    trig_t             clon;
    logic signed [27:0] h;
  } side_t;

  angle_t             lat_th, lon_th;
  trig_t              slat0, clat0, slon0, clon0;
  logic signed [27:0] hd_r [HD];
  side_t              side0;
  side_t              side_r [SIDE_DEPTH];

  logic [31:0] us_r;
  logic [63:0] sq_r;
  logic [30:0] s2_r;
  logic [63:0] e2p_r;
  logic [30:0] w_r;
  logic [63:0] sv_r [SQRT_STEPS];
  logic [63:0] sr_r [SQRT_STEPS];
  logic [30:0] rf;
  logic [62:0] dvd_r;
  logic [30:0] dvs_r;
  logic [30:0] rem_r [DIV_STEPS];
  logic [33:0] q_r [DIV_STEPS];
  logic [33:0] dlo_r [DIV_STEPS];
  logic [30:0] ds_r [DIV_STEPS];
  logic [64:0] nzp_r;
  logic [33:0] nq1_r, nq2_r, nz_r;
  logic [64:0] nzr;
  coord_t      rr_r, nzh_r, rc_r, p2a_r, p2b_r;
  mprod_t      rcp_r, zp_r, p0p_r, p1p_r;
  ecef_t       out_r;

  assign lat_th = angle_t'(lat_i) <<< ANG_SHIFT;
  assign lon_th = angle_t'(lon_i) <<< ANG_SHIFT;

  g2e_cordic #(.STAGES(STAGES)) u_lat (
    .clk(clk), .en(en), .theta_i(lat_th), .sin_o(slat0), .cos_o(clat0)
  );

  g2e_cordic #(.STAGES(STAGES)) u_lon (
    .clk(clk), .en(en), .theta_i(lon_th), .sin_o(slon0), .cos_o(clon0)
  );

  // height and trig values ride along the radius computation
  assign side0 = '{slat: slat0, clat: clat0, slon: slon0, clon: clon0, h: hd_r[HD-1]};

  always_ff @(posedge clk) begin
    if (en) begin
      hd_r[0] <= alt_i;
      for (int k = 1; k < HD; k++) hd_r[k] <= hd_r[k-1];
      side_r[0] <= side0;
      for (int k = 1; k < SIDE_DEPTH; k++) side_r[k] <= side_r[k-1];
    end
  end

  // w = 1 - e2 sin^2 lat
  always_ff @(posedge clk) begin
    if (en) begin
      us_r  <= slat0[32] ? 32'(-slat0) : 32'(slat0);
      sq_r  <= 64'(us_r) * 64'(us_r);
      s2_r  <= (sq_r[63:30] > 34'(1 << 30)) ? 31'(1 << 30) : sq_r[60:30];
      e2p_r <= 64'(E2_Q40) * 64'(s2_r);
      w_r   <= 31'(1 << 30) - 31'(e2p_r[63:40]);
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] v_in, r_in, t;
    if (k == 0) begin : g_first
      assign v_in = {3'b000, w_r, 30'd0};
      assign r_in = '0;
    end else begin : g_next
      assign v_in = sv_r[k-1];
      assign r_in = sr_r[k-1];
    end
    assign t = r_in + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (v_in >= t) begin
          sv_r[k] <= v_in - t;
          sr_r[k] <= (r_in >> 1) + BIT;
        end else begin
          sv_r[k] <= v_in;
          sr_r[k] <= r_in >> 1;
        end
      end
    end
  end

  // rounded dividend a / r
  assign rf = (sr_r[SQRT_STEPS-1][30:0] == '0) ? 31'd1 : sr_r[SQRT_STEPS-1][30:0];

  always_ff @(posedge clk) begin
    if (en) begin
      dvd_r <= {A_MM, 30'd0} + 63'(rf >> 1);
      dvs_r <= rf;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [30:0] rem_in, ds_in;
    logic [33:0] q_in, lo_in;
    logic [31:0] tr;
    if (k == 0) begin : g_first
      assign rem_in = {2'b00, dvd_r[62:34]};
      assign q_in = '0;
      assign lo_in = dvd_r[33:0];
      assign ds_in = dvs_r;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign q_in = q_r[k-1];
      assign lo_in = dlo_r[k-1];
      assign ds_in = ds_r[k-1];
    end
    assign tr = {rem_in, lo_in[DIV_STEPS-1-k]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (tr >= {1'b0, ds_in}) begin
          rem_r[k] <= 31'(tr - {1'b0, ds_in});
          q_r[k] <= {q_in[32:0], 1'b1};
        end else begin
          rem_r[k] <= tr[30:0];
          q_r[k] <= {q_in[32:0], 1'b0};
        end
        dlo_r[k] <= lo_in;
        ds_r[k] <= ds_in;
      end
    end
  end

  // polar radius factor and the radii plus height
  assign nzr = nzp_r + (65'd1 << 30);

  always_ff @(posedge clk) begin
    if (en) begin
      nzp_r <= 65'(q_r[DIV_STEPS-1]) * 65'(ONE_MINUS_E2_Q31);
      nq1_r <= q_r[DIV_STEPS-1];
      nz_r  <= nzr[64:31];
      nq2_r <= nq1_r;
      rr_r  <= coord_t'({4'b0000, nq2_r}) + coord_t'(side_r[73].h);
      nzh_r <= coord_t'({4'b0000, nz_r}) + coord_t'(side_r[73].h);
    end
  end

  // projection onto the earth-centered axes
  always_ff @(posedge clk) begin
    if (en) begin
      rcp_r <= mq_prod(rr_r, side_r[74].clat);
      zp_r  <= mq_prod(nzh_r, side_r[74].slat);
      rc_r  <= mq_round(rcp_r);
      p2a_r <= mq_round(zp_r);
      p0p_r <= mq_prod(rc_r, side_r[76].clon);
      p1p_r <= mq_prod(rc_r, side_r[76].slon);
      p2b_r <= p2a_r;
      out_r.x <= mq_round(p0p_r);
      out_r.y <= mq_round(p1p_r);
      out_r.z <= p2b_r;
      out_r.slat <= side_r[77].slat;
      out_r.clat <= side_r[77].clat;
      out_r.slon <= side_r[77].slon;
      out_r.clon <= side_r[77].clon;
    end
  end

  assign pos_o = out_r;

endmodule
`default_nettype wire

// File: design/geodetic_to_enu.sv
// geodetic fix to local east/north/up converter on the wgs84 ellipsoid
//
// in_ channel: one fix per item (latitude, longitude in degrees with 24
// fraction bits, height in mm). out_ channel: one item per fix with the
// east, north and up offsets in mm from the reference point, saturated.
// cfg_ channel: writes of the reference latitude, longitude and height,
// always ready; write it only while no item is in flight.
//
// the pipeline runs through the angle cordic, the 32-stage square root
// and the 34-stage radius divider. one item can be taken every cycle
// while the output is not held; the fix and the reference point run
// through two copies of the earth-centered conversion side by side.
// reset restores the default reference point and empties the pipeline.
// when the receiver stalls the whole pipeline holds in place and in_tready
// drops, so nothing is lost or repeated; the output register holds its
// item until it is taken.
`default_nettype none
module geodetic_to_enu import g2e_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DFLT
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // lat_deg[31:0], lon_deg[64:32], alt_mm[92:65], zero fill
  input  wire logic [95:0]  in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // east_mm[34:0], north_mm[69:35], up_mm[104:70], zero fill
  output logic [111:0]      out_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [32:0]  cfg_data
);

  localparam int LAT = CORDIC_STAGES + ANGLE_LAT + ECEF_TAIL + ROT_LAT;

  logic [31:0] ref_lat_r;
  logic [32:0] ref_lon_r;
  logic [27:0] ref_alt_r;
  logic        vld_r [LAT];
  logic        en;
  ecef_t       fix_p, ref_p;

  coord_t dx_r, dy_r, dz_r;
  trig_t  t1_slat_r, t1_clat_r, t1_slon_r, t1_clon_r;
  trig_t  t2_slat_r, t2_clat_r, t3_slat_r, t3_clat_r;
  mprod_t xcp_r, ysp_r, a1p_r, a2p_r, b3p_r, b4p_r;
  coord_t xc_r, ys_r, a1_r, a2_r, b3_r, b4_r;
  mprod_t m1p_r, m2p_r, m3p_r, m4p_r;
  coord_t a1d_r, a2d_r, b3d_r, b4d_r;
  coord_t m1_r, m2_r, m3_r, m4_r;
  coord_t a1e_r, a2e_r, b3e_r, b4e_r;
  sum_t   e_r, n_r, u_r;
  logic [34:0] east_r, north_r, up_r;

  // whole pipeline moves unless the output item is held
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  // reference point registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_lat_r <= REF_LAT_RST;
      ref_lon_r <= REF_LON_RST;
      ref_alt_r <= REF_ALT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_REF_LAT: ref_lat_r <= cfg_data[31:0];
        REG_REF_LON: ref_lon_r <= cfg_data;
        REG_REF_ALT: ref_alt_r <= cfg_data[27:0];
        default: ;
      endcase
    end
  end

  // item valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int k = 1; k < LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  g2e_ecef #(.STAGES(CORDIC_STAGES)) u_fix (
    .clk(clk), .en(en),
    .lat_i($signed(in_tdata[31:0])),
    .lon_i($signed(in_tdata[64:32])),
    .alt_i($signed(in_tdata[92:65])),
    .pos_o(fix_p)
  );

  g2e_ecef #(.STAGES(CORDIC_STAGES)) u_ref (
    .clk(clk), .en(en),
    .lat_i($signed(ref_lat_r)),
    .lon_i($signed(ref_lon_r)),
    .alt_i($signed(ref_alt_r)),
    .pos_o(ref_p)
  );

  // difference, then rotation into the local frame
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= fix_p.x - ref_p.x;
      dy_r <= fix_p.y - ref_p.y;
      dz_r <= fix_p.z - ref_p.z;
      t1_slat_r <= ref_p.slat;
      t1_clat_r <= ref_p.clat;
      t1_slon_r <= ref_p.slon;
      t1_clon_r <= ref_p.clon;

      xcp_r <= mq_prod(dx_r, t1_clon_r);
      ysp_r <= mq_prod(dy_r, t1_slon_r);
      a1p_r <= mq_prod(dx_r, t1_slon_r);
      a2p_r <= mq_prod(dy_r, t1_clon_r);
      b3p_r <= mq_prod(dz_r, t1_clat_r);
      b4p_r <= mq_prod(dz_r, t1_slat_r);
      t2_slat_r <= t1_slat_r;
      t2_clat_r <= t1_clat_r;

      xc_r <= mq_round(xcp_r);
      ys_r <= mq_round(ysp_r);
      a1_r <= mq_round(a1p_r);
      a2_r <= mq_round(a2p_r);
      b3_r <= mq_round(b3p_r);
      b4_r <= mq_round(b4p_r);
      t3_slat_r <= t2_slat_r;
      t3_clat_r <= t2_clat_r;

      m1p_r <= mq_prod(xc_r, t3_slat_r);
      m2p_r <= mq_prod(ys_r, t3_slat_r);
      m3p_r <= mq_prod(xc_r, t3_clat_r);
      m4p_r <= mq_prod(ys_r, t3_clat_r);
      a1d_r <= a1_r;
      a2d_r <= a2_r;
      b3d_r <= b3_r;
      b4d_r <= b4_r;

      m1_r <= mq_round(m1p_r);
      m2_r <= mq_round(m2p_r);
      m3_r <= mq_round(m3p_r);
      m4_r <= mq_round(m4p_r);
      a1e_r <= a1d_r;
      a2e_r <= a2d_r;
      b3e_r <= b3d_r;
      b4e_r <= b4d_r;

      e_r <= sum_t'(a2e_r) - sum_t'(a1e_r);
      n_r <= sum_t'(b3e_r) - sum_t'(m1_r) - sum_t'(m2_r);
      u_r <= sum_t'(m3_r) + sum_t'(m4_r) + sum_t'(b4e_r);

      east_r  <= sat35(e_r);
      north_r <= sat35(n_r);
      up_r    <= sat35(u_r);
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata = {7'd0, up_r, north_r, east_r};

endmodule
`default_nettype wire

// File: test/g2e_checker.sv
`timescale 1ns / 100ps
module g2e_checker import g2e_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [95:0]  in_tdata,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [111:0] out_tdata,
  input  wire logic         cfg_valid,
  input  wire logic         cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [32:0]  cfg_data,
  output int                errors,
  output int                pending,
  output int                checked
);

  localparam int STAGES = CORDIC_STAGES_DFLT;
  localparam longint OUT_HI = 64'sd17179869183;
  localparam longint OUT_LO = -64'sd17179869184;

  typedef struct packed {
    logic [34:0] east;
    logic [34:0] north;
    logic [34:0] up;
  } enu_t;

  enu_t        enu_q[$];
  longint      atan_q32[32];
  logic [31:0] ref_lat;
  logic [32:0] ref_lon;
  logic [27:0] ref_alt;

  // arctangent of 2^-i in degrees q32, odd power series
  initial begin
    longint acc;
    longint t;
    longint unsigned ua;
    int e;
    atan_q32[0] = 64'sd45 <<< 32;
    for (int i = 1; i < 32; i++) begin
      acc = 0;
      for (int k = 0; k < 32; k++) begin
        e = i * (2 * k + 1);
        if (e <= 60) begin
          t = (64'sd1 <<< (60 - e)) / longint'(2 * k + 1);
          acc = (k & 1) ? acc - t : acc + t;
        end
      end
      ua = 64'(acc);
      atan_q32[i] = longint'(((ua >> 28) * 64'd961263669) >> 24);
    end
  end

  // (a * b) / 2^30, rounded half away from zero
  function automatic longint mul_q30(input longint a, input longint b);
    bit neg;
    longint unsigned ua, ub, hi, lo, m;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? 64'(-a) : 64'(a);
    ub = b < 0 ? 64'(-b) : 64'(b);
    hi = ua >> 32;
    lo = ua & 64'hFFFFFFFF;
    m = ((hi * ub) << 2) + ((lo * ub + (64'd1 << 29)) >> 30);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // rotation cordic on a degree angle in q32, sine and cosine in q30
  function automatic void sin_cos_q30(input longint theta, output longint s,
                                      output longint c);
    longint full, half, quarter, z, x, y, dx, dy;
    bit flip;
    full = 64'sd360 <<< 32;
    half = 64'sd180 <<< 32;
    quarter = 64'sd90 <<< 32;
    z = theta % full;
    x = 64'sd652032874;
    y = 0;
    flip = 0;
    if (z < 0) z += full;
    if (z >= half) z -= full;
    if (z > quarter) begin
      z -= half;
      flip = 1;
    end else if (z < -quarter) begin
      z += half;
      flip = 1;
    end
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q32[i];
      end else begin
        x += dx; y -= dy; z += atan_q32[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  // geodetic point to earth-centered mm, with its trig terms
  function automatic void geo_to_ecef(input logic [31:0] lat_r, input logic [32:0] lon_r,
                                      input logic [27:0] alt_r,
                                      output longint px, output longint py,
                                      output longint pz, output longint slat,
                                      output longint clat, output longint slon,
                                      output longint clon);
    longint lat, lon, h, rc;
    longint unsigned us, s2, w, r, n, nz;
    lat = longint'($signed(lat_r)) * 256;
    lon = longint'($signed(lon_r)) * 256;
    h = longint'($signed(alt_r));
    sin_cos_q30(lat, slat, clat);
    sin_cos_q30(lon, slon, clon);
    us = slat < 0 ? 64'(-slat) : 64'(slat);
    s2 = (us * us) >> 30;
    if (s2 > (64'd1 << 30)) s2 = 64'd1 << 30;
    w = (64'd1 << 30) - ((64'd7360548640 * s2) >> 40);
    r = int_sqrt(w << 30);
    if (r == 0) r = 1;
    n = ((64'd6378137000 << 30) + (r >> 1)) / r;
    nz = (n * 64'd2133107576 + (64'd1 << 30)) >> 31;
    rc = mul_q30(longint'(n) + h, clat);
    px = mul_q30(rc, clon);
    py = mul_q30(rc, slon);
    pz = mul_q30(longint'(nz) + h, slat);
  endfunction

  function automatic logic [34:0] clip35(input longint v);
    if (v > OUT_HI) v = OUT_HI;
    if (v < OUT_LO) v = OUT_LO;
    return v[34:0];
  endfunction

  function automatic enu_t predict_enu(input logic [95:0] d);
    longint x, y, z, sl, cl, so, co;
    longint x0, y0, z0, sl0, cl0, so0, co0;
    longint xd, yd, zd, xc, ys, e, n, u;
    enu_t r;
    geo_to_ecef(d[31:0], d[64:32], d[92:65], x, y, z, sl, cl, so, co);
    geo_to_ecef(ref_lat, ref_lon, ref_alt, x0, y0, z0, sl0, cl0, so0, co0);
    xd = x - x0;
    yd = y - y0;
    zd = z - z0;
    xc = mul_q30(xd, co0);
    ys = mul_q30(yd, so0);
    e = -mul_q30(xd, so0) + mul_q30(yd, co0);
    n = -mul_q30(xc, sl0) - mul_q30(ys, sl0) + mul_q30(zd, cl0);
    u = mul_q30(xc, cl0) + mul_q30(ys, cl0) + mul_q30(zd, sl0);
    r.east = clip35(e);
    r.north = clip35(n);
    r.up = clip35(u);
    return r;
  endfunction

  assign pending = enu_q.size();

  // reference writes, expectations and comparison
  always @(posedge clk) begin
    enu_t exp_v, got;
    if (!rst_n) begin
      ref_lat <= REF_LAT_RST;
      ref_lon <= REF_LON_RST;
      ref_alt <= REF_ALT_RST;
      enu_q.delete();
      errors <= 0;
      checked <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_REF_LAT: ref_lat <= cfg_data[31:0];
          REG_REF_LON: ref_lon <= cfg_data;
          REG_REF_ALT: ref_alt <= cfg_data[27:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) enu_q.push_back(predict_enu(in_tdata));
      if (out_tvalid && out_tready) begin
        got.east = out_tdata[34:0];
        got.north = out_tdata[69:35];
        got.up = out_tdata[104:70];
        checked <= checked + 1;
        if (enu_q.size() == 0) begin
          $display("%0t: unexpected item, got e=%0d n=%0d u=%0d", $time,
                   $signed(got.east), $signed(got.north), $signed(got.up));
          errors <= errors + 1;
        end else begin
          exp_v = enu_q.pop_front();
          if (exp_v.east !== got.east || exp_v.north !== got.north
              || exp_v.up !== got.up || out_tdata[111:105] !== '0) begin
            $display("%0t: mismatch expected e=%0d n=%0d u=%0d actual e=%0d n=%0d u=%0d",
                     $time, $signed(exp_v.east), $signed(exp_v.north), $signed(exp_v.up),
                     $signed(got.east), $signed(got.north), $signed(got.up));
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// File: test/tb_geodetic_to_enu.sv
`timescale 1ns / 100ps
module tb_geodetic_to_enu import g2e_pkg::*;;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam longint LAT_MAX = 64'sd1509949440;
  localparam longint LON_MAX = 64'sd3019898880;
  localparam int SETTLE = 140;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 255;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [95:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [32:0]  cfg_data = '0;

  int  errors, pending, checked;
  int  items_sent = 0;
  int  cfg_writes = 0;
  int  idle_cnt = 0;
  bit  quiet = 0;
  logic [31:0] cur_lat = REF_LAT_RST;
  logic [32:0] cur_lon = REF_LON_RST;
  logic [27:0] cur_alt = REF_ALT_RST;

  geodetic_to_enu u_top (.*);

  g2e_checker u_chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls in bursts
  initial begin
    int n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (quiet) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        n = $urandom_range(1, 18);
        out_tready <= ($urandom_range(0, 2) == 0) ? 1'b0 : 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_fix(input logic [31:0] lat, input logic [32:0] lon,
                          input logic [27:0] alt);
    in_tvalid <= 1'b1;
    in_tdata <= {3'b0, alt, lon, lat};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    items_sent++;
    // sender gap after some items
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic write_ref(input logic [1:0] idx, input logic [32:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      REG_REF_LAT: cur_lat = val[31:0];
      REG_REF_LON: cur_lon = val;
      REG_REF_ALT: cur_alt = val[27:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_ref(input longint lat, input longint lon, input longint alt);
    drain();
    write_ref(REG_REF_LAT, 33'(lat));
    write_ref(REG_REF_LON, 33'(lon));
    write_ref(REG_REF_ALT, 33'(alt));
  endtask

  // random fix: raw bits, anywhere in range, or near the reference
  task automatic send_random;
    int mode;
    longint lat, lon, alt;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      send_fix($urandom, 33'({$urandom_range(0, 1), $urandom}), 28'($urandom));
    end else if (mode < 6) begin
      lat = longint'($urandom_range(0, 32'd3019898880)) - LAT_MAX;
      lon = longint'($urandom_range(0, 32'd3019898880)) * 2 + $urandom_range(0, 1) - LON_MAX;
      alt = longint'($urandom_range(0, 101000000)) - 1000000;
      send_fix(32'(lat), 33'(lon), 28'(alt));
    end else begin
      lat = longint'($signed(cur_lat)) + longint'($urandom_range(0, 200000)) - 100000;
      lon = longint'($signed(cur_lon)) + longint'($urandom_range(0, 200000)) - 100000;
      alt = longint'($signed(cur_alt)) + longint'($urandom_range(0, 2000000)) - 1000000;
      send_fix(32'(lat), 33'(lon), 28'(alt));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, wraps, out-of-range angles, the reference itself
    send_fix(cur_lat, cur_lon, cur_alt);
    send_fix(32'(LAT_MAX), 33'd0, 28'd0);
    send_fix(32'(-LAT_MAX), 33'd0, 28'd0);
    send_fix(32'h7FFFFFFF, 33'd0, 28'd0);
    send_fix(32'h80000000, 33'd0, 28'd0);
    send_fix(32'd0, 33'(LON_MAX), 28'd0);
    send_fix(32'd0, 33'(-LON_MAX), 28'd0);
    send_fix(32'd0, 33'h0FFFFFFFF, 28'd0);
    send_fix(32'd0, 33'h100000000, 28'd0);
    send_fix(32'd0, 33'h1FFFFFFFF, 28'd0);
    send_fix(32'd0, 33'd0, 28'(-1000000));
    send_fix(32'd0, 33'd0, 28'd100000000);
    send_fix(32'd0, 33'd0, 28'h7FFFFFF);
    send_fix(32'd0, 33'd0, 28'h8000000);
    send_fix(32'hFFFFFFFF, 33'h1FFFFFFFF, 28'hFFFFFFF);
    send_fix(32'd0, 33'd0, 28'd0);
    send_fix(32'(-LAT_MAX), 33'(-LON_MAX), 28'h7FFFFFF);
    send_fix(32'(-765564375), 33'(64'sd155940021 - LON_MAX), 28'd231507);
    send_fix(32'd1, 33'd1, 28'd1);

    // random phases over several reference points
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: set_ref(LAT_MAX, -LON_MAX, 100000000);
        2: set_ref(-LAT_MAX, LON_MAX, -1000000);
        3: begin
          set_ref(64'sh7FFFFFFF, 64'sh0FFFFFFFF, 64'sh7FFFFFF);
          write_ref(REG_UNUSED, 33'h1FFFFFFFF);
        end
        4: set_ref(-64'sh80000000, -64'sh100000000, -64'sh8000000);
        5: begin
          set_ref(longint'($urandom_range(0, 32'd3019898880)) - LAT_MAX,
                  longint'($urandom_range(0, 32'd3019898880)) * 2 - LON_MAX,
                  longint'($urandom_range(0, 101000000)) - 1000000);
          quiet = 1;
        end
        default: ;
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_random();
        // one hold-off until the pipeline is empty
        if (ph == 0 && i == PHASE_ITEMS / 2) drain();
      end
    end

    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("sent %0d fixes, checked %0d results, %0d reference writes", items_sent,
             checked, cfg_writes);
    $display("reference points covered pole, antimeridian, height and raw-field extremes");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: geodetic_to_enu.f
design/g2e_pkg.sv
design/g2e_cordic.sv
design/g2e_ecef.sv
design/geodetic_to_enu.sv
test/g2e_checker.sv
test/tb_geodetic_to_enu.sv
